>>> hw/rtl/mips_rtype_execute_assert.svh
// assertion macros shared by the execute unit
`ifndef MIPS_RTYPE_EXECUTE_ASSERT_SVH
`define MIPS_RTYPE_EXECUTE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MRE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mre_pkg.sv
// types, widths, funct and status codes of the execute unit
package mre_pkg;

    localparam int XLEN   = 32;
    localparam int REG_AW = 5;
    localparam int NREGS  = 32;

    localparam logic [5:0] F_SLL  = 6'h00;
    localparam logic [5:0] F_SRL  = 6'h02;
    localparam logic [5:0] F_JR   = 6'h08;
    localparam logic [5:0] F_ADD  = 6'h20;
    localparam logic [5:0] F_ADDU = 6'h21;
    localparam logic [5:0] F_SUB  = 6'h22;
    localparam logic [5:0] F_SUBU = 6'h23;
    localparam logic [5:0] F_AND  = 6'h24;
    localparam logic [5:0] F_SLT  = 6'h2a;
    localparam logic [5:0] F_SLTU = 6'h2b;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ILLEGAL  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic KIND_EXEC = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } wr_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [XLEN-1:0]   next_pc;
        logic [XLEN-1:0]   write_value;
        logic [REG_AW-1:0] dest_index;
        logic              wrote;
    } res_t;

endpackage

>>> hw/rtl/mips_rtype_execute.sv
// top level of the r-format execute unit
//
//  port group | dir | payload
//  s_*        | in  | tuser: kind; tdata: instr_word, load_index, load_value
//  m_*        | out | tdata: wrote, dest_index, write_value, next_pc, status
//
// one item per cycle sustained while m_tready is high; each item passes the stage 1 registers, then the result register
// register file read issues at input accept, data returns in the next cycle from ram
// the item writes back as it leaves the execute stage; a bypass register covers
// the write that lands on the same edge as the next item's read
// rst_n clears pc, valid bits and stage valids; no clearing pass is needed
// a stalled result beat holds one item in execute, ready drops only when both are full
`include "mips_rtype_execute_assert.svh"

module mips_rtype_execute
    import mre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // instr_word, load_index, load_value, zero pad
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // wrote, dest_index, write_value, next_pc, status
);

    logic              in_fire;
    logic              s1_fire;
    logic              s1_vld_reg;
    logic              s1_vld_next;
    logic              s1_kind_reg;
    logic [XLEN-1:0]   s1_word_reg;
    logic [REG_AW-1:0] s1_lidx_reg;
    logic [XLEN-1:0]   s1_lval_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    res_t              out_res_reg;
    logic [XLEN-1:0]   pc_reg;
    logic [XLEN-1:0]   pc_next;
    logic [REG_AW-1:0] raddr_a;
    logic [REG_AW-1:0] raddr_b;
    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    res_t              res;
    wr_t               alu_wr;
    wr_t               rf_wr;

    assign s1_fire  = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;

    // re-read the held item's operands while it waits
    assign raddr_a = in_fire ? s_tdata[25:21] : s1_word_reg[25:21];
    assign raddr_b = in_fire ? s_tdata[20:16] : s1_word_reg[20:16];

    mre_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rs_q    (s1_word_reg[25:21]),
        .rt_q    (s1_word_reg[20:16]),
        .wr      (rf_wr),
        .a       (op_a),
        .b       (op_b)
    );

    mre_alu u_alu (
        .kind       (s1_kind_reg),
        .word       (s1_word_reg),
        .load_index (s1_lidx_reg),
        .load_value (s1_lval_reg),
        .a          (op_a),
        .b          (op_b),
        .pc         (pc_reg),
        .res        (res),
        .wr         (alu_wr)
    );

    always_comb
    begin
        rf_wr    = alu_wr;
        rf_wr.en = alu_wr.en && s1_fire;
    end

    always_comb
    begin
        s1_vld_next  = in_fire || (s1_vld_reg && !s1_fire);
        out_vld_next = s1_fire || (out_vld_reg && !m_tready);
        pc_next      = s1_fire ? res.next_pc : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            pc_reg      <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= s_tuser;
            s1_word_reg <= s_tdata[31:0];
            s1_lidx_reg <= s_tdata[36:32];
            s1_lval_reg <= s_tdata[68:37];
        end
        if (s1_fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg;

    `MRE_ASSERT_NOW(a_no_zero_write, rf_wr.en, rf_wr.addr != '0, "write to register zero")
    `MRE_ASSERT_NOW(a_write_ok_status, rf_wr.en, res.status == ST_OK, "write with bad status")
    `MRE_ASSERT_NEXT(a_pc_hold, !s1_fire, $stable(pc_reg), "pc moved without an item")
    `MRE_ASSERT_NOW(a_no_overrun, s1_fire, !out_vld_reg || m_tready, "result overwritten")
    `MRE_ASSERT_NOW(a_load_pc, s1_fire && s1_kind_reg == KIND_LOAD, res.next_pc == pc_reg,
        "preload changed pc")

endmodule

>>> hw/rtl/mre_ram.sv
// generic single-write, single-read ram with registered read (read-first)
module mre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mre_regfile.sv
// register file: two ram copies for two read ports, valid bits and write bypass
module mre_regfile
    import mre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [REG_AW-1:0] raddr_a,
    input  logic [REG_AW-1:0] raddr_b,
    input  logic [REG_AW-1:0] rs_q,
    input  logic [REG_AW-1:0] rt_q,
    input  wr_t               wr,
    output logic [XLEN-1:0]   a,
    output logic [XLEN-1:0]   b
);

    logic [XLEN-1:0]   ram_a;
    logic [XLEN-1:0]   ram_b;
    logic [NREGS-1:0]  vld_reg;
    logic [NREGS-1:0]  vld_next;
    logic              byp_vld_reg;
    logic [REG_AW-1:0] byp_addr_reg;
    logic [XLEN-1:0]   byp_data_reg;

    mre_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_ram_a (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr_a),
        .rdata (ram_a)
    );

    mre_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_ram_b (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr_b),
        .rdata (ram_b)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (wr.en)
        begin
            vld_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            byp_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            byp_vld_reg <= wr.en;
        end
    end

    // write landing in the same edge as the read is not seen by the ram
    always_ff @(posedge clk)
    begin
        byp_addr_reg <= wr.addr;
        byp_data_reg <= wr.data;
    end

    always_comb
    begin
        if (byp_vld_reg && byp_addr_reg == rs_q)
        begin
            a = byp_data_reg;
        end
        else
        begin
            a = vld_reg[rs_q] ? ram_a : '0;
        end
        if (byp_vld_reg && byp_addr_reg == rt_q)
        begin
            b = byp_data_reg;
        end
        else
        begin
            b = vld_reg[rt_q] ? ram_b : '0;
        end
    end

endmodule

>>> hw/rtl/mre_alu.sv
// decode and execute of one r-format word or preload
module mre_alu
    import mre_pkg::*;
(
    input  logic              kind,
    input  logic [XLEN-1:0]   word,
    input  logic [REG_AW-1:0] load_index,
    input  logic [XLEN-1:0]   load_value,
    input  logic [XLEN-1:0]   a,
    input  logic [XLEN-1:0]   b,
    input  logic [XLEN-1:0]   pc,
    output res_t              res,
    output wr_t               wr
);

    logic [5:0]        funct;
    logic [4:0]        shamt;
    logic [REG_AW-1:0] rd;
    logic              is_sub;
    logic [XLEN-1:0]   sum;
    logic              ovf;
    logic [XLEN-1:0]   r;
    logic              wr_ok;
    logic [1:0]        st;
    logic [XLEN-1:0]   npc;
    logic [REG_AW-1:0] dst;
    logic [XLEN-1:0]   val;

    assign funct  = word[5:0];
    assign shamt  = word[10:6];
    assign rd     = word[15:11];
    assign is_sub = (funct == F_SUB) || (funct == F_SUBU);
    assign sum    = a + (is_sub ? ~b : b) + {{(XLEN-1){1'b0}}, is_sub};
    assign ovf    = is_sub ? (((a ^ b) & (a ^ sum)) >> (XLEN-1)) != '0
                           : (((a ^ sum) & (b ^ sum)) >> (XLEN-1)) != '0;

    always_comb
    begin
        r     = '0;
        wr_ok = 1'b0;
        st    = ST_OK;
        npc   = pc + PC_STEP;
        unique case (funct) inside
            F_ADD, F_SUB:
            begin
                r     = sum;
                wr_ok = !ovf;
                st    = ovf ? ST_OVERFLOW : ST_OK;
            end
            F_ADDU, F_SUBU:
            begin
                r     = sum;
                wr_ok = 1'b1;
            end
            F_AND:
            begin
                r     = a & b;
                wr_ok = 1'b1;
            end
            F_SLT:
            begin
                r     = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
                wr_ok = 1'b1;
            end
            F_SLTU:
            begin
                r     = {{(XLEN-1){1'b0}}, a < b};
                wr_ok = 1'b1;
            end
            F_SLL:
            begin
                r     = b << shamt;
                wr_ok = 1'b1;
            end
            F_SRL:
            begin
                r     = b >> shamt;
                wr_ok = 1'b1;
            end
            F_JR:
            begin
                npc = a;
            end
            default:
            begin
                st = ST_ILLEGAL;
            end
        endcase

        if (kind == KIND_LOAD)
        begin
            r     = load_value;
            wr_ok = 1'b1;
            st    = ST_OK;
            npc   = pc;
            dst   = load_index;
        end
        else
        begin
            dst = rd;
        end

        val = r;
        wr.en   = wr_ok && dst != '0;
        wr.addr = dst;
        wr.data = val;

        res.wrote       = wr.en;
        res.dest_index  = wr.en ? dst : '0;
        res.write_value = wr.en ? val : '0;
        res.next_pc     = npc;
        res.status      = st;
    end

endmodule

>>> verif/mips_rtype_execute_checker.sv
// checker for the r-format execute unit: tracks registers and pc, compares every result beat
module mips_rtype_execute_checker
    import mre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // instr_word, load_index, load_value, zero pad
    input  logic        s_tuser,   // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // wrote, dest_index, write_value, next_pc, status
    output int          fail_count,
    output int          pending,
    output int          checked_count,
    output int          overflow_count,
    output int          illegal_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [XLEN-1:0] gpr [NREGS];
    logic [XLEN-1:0] pc_q;
    res_t            expected_results [$];
    int              errs;
    int              n_checked;
    int              n_ovf;
    int              n_ill;

    function automatic res_t execute_item(logic kind, logic [31:0] word,
                                          logic [4:0] idx, logic [31:0] val);
        res_t            r;
        logic [5:0]      fn;
        logic [4:0]      sa;
        logic [4:0]      rd;
        logic [4:0]      rt;
        logic [4:0]      rs;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] alu;
        logic            do_write;
        logic [1:0]      st;
        r = '0;
        if (kind == KIND_LOAD)
        begin
            r.next_pc = pc_q;
            if (idx != 5'd0)
            begin
                gpr[idx]      = val;
                r.wrote       = 1'b1;
                r.dest_index  = idx;
                r.write_value = val;
            end
            return r;
        end
        fn       = word[5:0];
        sa       = word[10:6];
        rd       = word[15:11];
        rt       = word[20:16];
        rs       = word[25:21];
        a        = gpr[rs];
        b        = gpr[rt];
        alu      = '0;
        do_write = 1'b1;
        st       = ST_OK;
        case (fn)
            F_ADD:
            begin
                alu = a + b;
                if ((a[31] == b[31]) && (alu[31] != a[31]))
                begin
                    st       = ST_OVERFLOW;
                    do_write = 1'b0;
                end
            end
            F_ADDU: alu = a + b;
            F_SUB:
            begin
                alu = a - b;
                if ((a[31] != b[31]) && (alu[31] != a[31]))
                begin
                    st       = ST_OVERFLOW;
                    do_write = 1'b0;
                end
            end
            F_SUBU: alu = a - b;
            F_AND:  alu = a & b;
            F_SLT:  alu = {31'd0, ($signed(a) < $signed(b))};
            F_SLTU: alu = {31'd0, (a < b)};
            F_SLL:  alu = b << sa;
            F_SRL:  alu = b >> sa;
            F_JR:
            begin
                pc_q      = a;
                r.next_pc = a;
                return r;
            end
            default:
            begin
                st       = ST_ILLEGAL;
                do_write = 1'b0;
            end
        endcase
        pc_q      = pc_q + PC_STEP;
        r.next_pc = pc_q;
        r.status  = st;
        if (do_write && (rd != 5'd0))
        begin
            gpr[rd]       = alu;
            r.wrote       = 1'b1;
            r.dest_index  = rd;
            r.write_value = alu;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        res_t got_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
                gpr[i] = '0;
            pc_q = '0;
            expected_results.delete();
            errs      = 0;
            n_checked = 0;
            n_ovf     = 0;
            n_ill     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_r = res_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errs++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    n_checked++;
                    if (exp_r.status == ST_OVERFLOW)
                        n_ovf++;
                    if (exp_r.status == ST_ILLEGAL)
                        n_ill++;
                    if (got_r.wrote !== exp_r.wrote)
                    begin
                        $error("wrote: expected %0d, got %0d", exp_r.wrote, got_r.wrote);
                        errs++;
                    end
                    if (got_r.dest_index !== exp_r.dest_index)
                    begin
                        $error("dest_index: expected %0d, got %0d",
                               exp_r.dest_index, got_r.dest_index);
                        errs++;
                    end
                    if (got_r.write_value !== exp_r.write_value)
                    begin
                        $error("write_value: expected %h, got %h",
                               exp_r.write_value, got_r.write_value);
                        errs++;
                    end
                    if (got_r.next_pc !== exp_r.next_pc)
                    begin
                        $error("next_pc: expected %h, got %h", exp_r.next_pc, got_r.next_pc);
                        errs++;
                    end
                    if (got_r.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_item(s_tuser, s_tdata[31:0],
                                                        s_tdata[36:32], s_tdata[68:37]));
        end
        fail_count     <= errs;
        pending        <= expected_results.size();
        checked_count  <= n_checked;
        overflow_count <= n_ovf;
        illegal_count  <= n_ill;
    end

endmodule

>>> verif/tb_mips_rtype_execute.sv
// testbench top for the r-format execute unit: directed and random instruction streams
module tb_mips_rtype_execute
    import mre_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_ITEMS = 500;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    int fail_count;
    int pending;
    int checked_count;
    int overflow_count;
    int illegal_count;
    int idle_cycles = 0;
    int load_sent   = 0;
    int jr_sent     = 0;
    bit steady      = 1'b0;

    logic [5:0] legal_functs [10] = '{F_SLL, F_SRL, F_JR, F_ADD, F_ADDU,
                                      F_SUB, F_SUBU, F_AND, F_SLT, F_SLTU};

    mips_rtype_execute u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mips_rtype_execute_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .overflow_count (overflow_count),
        .illegal_count  (illegal_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [31:0] rword(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sa, logic [5:0] fn);
        return {op, rs, rt, rd, sa, fn};
    endfunction

    task automatic send_item(logic kind, logic [31:0] word, logic [4:0] idx,
                             logic [31:0] val);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, val, idx, word};
        if (kind == KIND_LOAD)
            load_sent++;
        else if (word[5:0] == F_JR)
            jr_sent++;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("mips_rtype_execute regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int          sel;
        logic [31:0] word;
        logic [31:0] val;
        logic [5:0]  fn;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register extremes, every funct, overflow, dropped writes, jr and pc wrap
        send_item(KIND_LOAD, $urandom, 5'd1, 32'h7fff_ffff);
        send_item(KIND_LOAD, $urandom, 5'd2, 32'h8000_0000);
        send_item(KIND_LOAD, $urandom, 5'd3, 32'hffff_ffff);
        send_item(KIND_LOAD, $urandom, 5'd4, 32'h0000_0001);
        send_item(KIND_LOAD, $urandom, 5'd0, 32'hffff_ffff);
        send_item(KIND_EXEC, rword(6'h00, 5'd1, 5'd4, 5'd5, 5'd0, F_ADD), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd4, 5'd4, 5'd5, 5'd0, F_ADD), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd1, 5'd4, 5'd6, 5'd7, F_ADDU), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd2, 5'd4, 5'd7, 5'd0, F_SUB), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd3, 5'd4, 5'd7, 5'd0, F_SUB), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd2, 5'd4, 5'd8, 5'd0, F_SUBU), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd3, 5'd1, 5'd9, 5'd0, F_AND), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd2, 5'd1, 5'd10, 5'd0, F_SLT), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd2, 5'd1, 5'd11, 5'd0, F_SLTU), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd0, 5'd3, 5'd12, 5'd31, F_SLL), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd0, 5'd3, 5'd13, 5'd31, F_SRL), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd0, 5'd1, 5'd14, 5'd0, F_SLL), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h3f, 5'd1, 5'd4, 5'd0, 5'd0, F_ADDU), 5'd31,
                  32'hffff_ffff);
        send_item(KIND_EXEC, rword(6'h23, 5'd1, 5'd2, 5'd20, 5'd0, 6'h3f), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd3, 5'd0, 5'd15, 5'd9, F_JR), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd4, 5'd0, 5'd15, 5'd0, F_ADDU), 5'd0, 32'd0);
        send_item(KIND_LOAD, 32'hffff_ffff, 5'd31, 32'd0);
        send_item(KIND_EXEC, rword(6'h00, 5'd4, 5'd0, 5'd0, 5'd0, F_JR), 5'd0, 32'd0);
        send_item(KIND_EXEC, rword(6'h15, 5'd1, 5'd2, 5'd16, 5'd0, F_SLT), 5'd0, 32'd0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if ((i % 50) == 0)
                steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0:       val = 32'h7fff_ffff;
                1:       val = 32'h8000_0000;
                2:       val = 32'hffff_ffff;
                3:       val = $urandom_range(0, 8);
                default: val = $urandom;
            endcase
            sel  = $urandom_range(0, 99);
            word = $urandom;
            if (sel < 25)
                send_item(KIND_LOAD, word, 5'($urandom), val);
            else
            begin
                fn = (sel < 88) ? legal_functs[$urandom_range(0, 9)] : 6'($urandom);
                word[5:0] = fn;
                send_item(KIND_EXEC, word, 5'($urandom), val);
            end
        end
        s_tvalid <= 1'b0;

        // let the checker count the last beat before polling
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("checked %0d result beats: %0d preloads, %0d jr sent", checked_count,
                 load_sent, jr_sent);
        $display("status seen: %0d overflow, %0d unknown funct", overflow_count,
                 illegal_count);
        if (fail_count == 0 && pending == 0)
            $display("mips_rtype_execute regression: pass");
        else
            $display("mips_rtype_execute regression: fail");
        $finish;
    end

endmodule
